>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the load table RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active low)
`define LTNU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked check that also holds during reset
`define LTNU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ltnu_pkg.sv
// ----------------------------------------------------------------------------
// ltnu_pkg
// Shared constants, types and codes of the load table with min/max query.
// ----------------------------------------------------------------------------
package ltnu_pkg;

    localparam int ENTRIES   = 64;
    localparam int ID_BITS   = 16;
    localparam int LOAD_W    = 32;
    localparam int STAMP_W   = 48;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_KEPT     = 2'd0,
        ST_REPLACED = 2'd1,
        ST_INSERTED = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic              start;
        logic              rd;
        logic [ADDR_W-1:0] rd_slot;
        logic              commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] filled;
        logic             out_free;
    } t_sts;

endpackage

>>> src/ltnu_ctrl.sv
// ----------------------------------------------------------------------------
// ltnu_ctrl
// Sequencer: accepts an item, walks the valid slots, then commits the result.
// ----------------------------------------------------------------------------
module ltnu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ltnu_pkg::t_sts i_sts,
    output ltnu_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic [ltnu_pkg::CNT_W-1:0]   r_addr;
    logic [ltnu_pkg::CNT_W-1:0]   n_addr;
    logic                         scan_end;

    assign o_ready  = (r_state == S_IDLE);
    assign scan_end = (r_addr == i_sts.filled);

    always_comb begin
        o_cmd.start   = i_valid && o_ready;
        o_cmd.rd      = (r_state == S_SCAN) && !scan_end;
        o_cmd.rd_slot = r_addr[ltnu_pkg::ADDR_W-1:0];
        o_cmd.commit  = (r_state == S_COMMIT) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (o_cmd.commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

endmodule

>>> src/ltnu_dp.sv
// ----------------------------------------------------------------------------
// ltnu_dp
// Table memory, id match, running min/max and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ltnu_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ltnu_pkg::t_cmd                   i_cmd,
    output ltnu_pkg::t_sts                   o_sts,
    input  logic [ltnu_pkg::ID_BITS-1:0]     i_proc_id,
    input  logic [ltnu_pkg::LOAD_W-1:0]      i_load,
    input  logic [ltnu_pkg::STAMP_W-1:0]     i_stamp,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic [1:0]                       o_status,
    output logic [ltnu_pkg::CNT_W-1:0]       o_entry_count,
    output logic [ltnu_pkg::ID_BITS-1:0]     o_min_proc,
    output logic [ltnu_pkg::LOAD_W-1:0]      o_min_load,
    output logic [ltnu_pkg::ID_BITS-1:0]     o_max_proc,
    output logic [ltnu_pkg::LOAD_W-1:0]      o_max_load
);

    // table memory
    logic [ltnu_pkg::ID_BITS-1:0] r_mem_id    [ltnu_pkg::ENTRIES];
    logic [ltnu_pkg::LOAD_W-1:0]  r_mem_load  [ltnu_pkg::ENTRIES];
    logic [ltnu_pkg::STAMP_W-1:0] r_mem_stamp [ltnu_pkg::ENTRIES];
    logic [ltnu_pkg::ID_BITS-1:0] r_q_id;
    logic [ltnu_pkg::LOAD_W-1:0]  r_q_load;
    logic [ltnu_pkg::STAMP_W-1:0] r_q_stamp;

    // current item
    logic [ltnu_pkg::ID_BITS-1:0] r_id;
    logic [ltnu_pkg::LOAD_W-1:0]  r_ld;
    logic [ltnu_pkg::STAMP_W-1:0] r_st;

    // scan state
    logic                         r_rd_vld;
    logic [ltnu_pkg::ADDR_W-1:0]  r_rd_slot;
    logic                         r_hit;
    logic                         r_newer;
    logic [ltnu_pkg::ADDR_W-1:0]  r_hit_slot;
    logic                         r_any;
    logic [ltnu_pkg::ID_BITS-1:0] r_min_id;
    logic [ltnu_pkg::LOAD_W-1:0]  r_min_ld;
    logic [ltnu_pkg::ID_BITS-1:0] r_max_id;
    logic [ltnu_pkg::LOAD_W-1:0]  r_max_ld;
    logic [ltnu_pkg::CNT_W-1:0]   r_filled;

    // result register
    logic                         r_o_valid;
    ltnu_pkg::t_status            r_o_status;
    logic [ltnu_pkg::CNT_W-1:0]   r_o_count;
    logic [ltnu_pkg::ID_BITS-1:0] r_o_min_id;
    logic [ltnu_pkg::LOAD_W-1:0]  r_o_min_ld;
    logic [ltnu_pkg::ID_BITS-1:0] r_o_max_id;
    logic [ltnu_pkg::LOAD_W-1:0]  r_o_max_ld;

    logic                         match;
    logic                         newer;
    logic [ltnu_pkg::LOAD_W-1:0]  eff_ld;
    logic                         ins;
    logic                         we;
    logic [ltnu_pkg::ADDR_W-1:0]  wslot;
    ltnu_pkg::t_status            n_status;
    logic [ltnu_pkg::ID_BITS-1:0] n_min_id;
    logic [ltnu_pkg::LOAD_W-1:0]  n_min_ld;
    logic [ltnu_pkg::ID_BITS-1:0] n_max_id;
    logic [ltnu_pkg::LOAD_W-1:0]  n_max_ld;

    // ids are unique in the table, so the first match is the only one
    assign match  = r_rd_vld && !r_hit && (r_q_id == r_id);
    assign newer  = r_st > r_q_stamp;
    assign eff_ld = (match && newer) ? r_ld : r_q_load;

    assign ins   = !r_hit && (r_filled < ltnu_pkg::FULL_CNT);
    assign we    = i_cmd.commit && ((r_hit && r_newer) || ins);
    assign wslot = r_hit ? r_hit_slot : r_filled[ltnu_pkg::ADDR_W-1:0];

    always_comb begin
        n_min_id = r_min_id;
        n_min_ld = r_min_ld;
        n_max_id = r_max_id;
        n_max_ld = r_max_ld;
        if (r_hit) begin
            n_status = r_newer ? ltnu_pkg::ST_REPLACED : ltnu_pkg::ST_KEPT;
        end else if (ins) begin
            n_status = ltnu_pkg::ST_INSERTED;
            // appended entry sits in the highest slot: strict compares
            if (!r_any || (r_ld < r_min_ld)) begin
                n_min_id = r_id;
                n_min_ld = r_ld;
            end
            if (!r_any || (r_ld > r_max_ld)) begin
                n_max_id = r_id;
                n_max_ld = r_ld;
            end
        end else begin
            n_status = ltnu_pkg::ST_DROPPED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_id[wslot]    <= r_id;
            r_mem_load[wslot]  <= r_ld;
            r_mem_stamp[wslot] <= r_st;
        end
        if (i_cmd.rd) begin
            r_q_id    <= r_mem_id[i_cmd.rd_slot];
            r_q_load  <= r_mem_load[i_cmd.rd_slot];
            r_q_stamp <= r_mem_stamp[i_cmd.rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_id <= i_proc_id;
            r_ld <= i_load;
            r_st <= i_stamp;
        end
        r_rd_slot <= i_cmd.rd_slot;
        if (match) begin
            r_hit_slot <= r_rd_slot;
            r_newer    <= newer;
        end
        if (r_rd_vld) begin
            if (!r_any || (eff_ld < r_min_ld)) begin
                r_min_id <= r_q_id;
                r_min_ld <= eff_ld;
            end
            if (!r_any || (eff_ld > r_max_ld)) begin
                r_max_id <= r_q_id;
                r_max_ld <= eff_ld;
            end
        end
        if (i_cmd.commit) begin
            r_o_status <= n_status;
            r_o_count  <= ins ? r_filled + 1'b1 : r_filled;
            r_o_min_id <= n_min_id;
            r_o_min_ld <= n_min_ld;
            r_o_max_id <= n_max_id;
            r_o_max_ld <= n_max_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_any     <= 1'b0;
            r_filled  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.start) begin
                r_hit <= 1'b0;
                r_any <= 1'b0;
            end else begin
                if (match) begin
                    r_hit <= 1'b1;
                end
                if (r_rd_vld) begin
                    r_any <= 1'b1;
                end
            end
            if (i_cmd.commit && ins) begin
                r_filled <= r_filled + 1'b1;
            end
            if (i_cmd.commit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.filled   = r_filled;
    assign o_sts.out_free = !r_o_valid || i_ready;

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;
    assign o_min_proc    = r_o_min_id;
    assign o_min_load    = r_o_min_ld;
    assign o_max_proc    = r_o_max_id;
    assign o_max_load    = r_o_max_ld;

    `LTNU_ASSERT(a_filled_range, i_clk, i_rst_n, r_filled <= ltnu_pkg::FULL_CNT, "fill count overflow")
    `LTNU_ASSERT(a_commit_free, i_clk, i_rst_n, i_cmd.commit |-> (!r_o_valid || i_ready), "result overwritten")
    `LTNU_ASSERT(a_count_match, i_clk, i_rst_n, $past(i_cmd.commit) |-> (r_o_count == r_filled), "count mismatch")
    `LTNU_ASSERT(a_result_nonempty, i_clk, i_rst_n, r_o_valid |-> (r_o_count != '0), "empty table result")

endmodule

>>> src/load_table_newest_update_minmax_unit.sv
// ----------------------------------------------------------------------------
// load_table_newest_update_minmax_unit
// Processor load table: newest-report update, append, and min/max query.
// ----------------------------------------------------------------------------
// Each input item is one load report (id, Q16.16 load, stamp). The table
// sits in a memory with one read and one write port, and the scan reads one
// slot per cycle for id match and min/max. The final scan step, with no read,
// compares the last slot read, then come a drain state and a commit state
// that writes the slot and loads the result register. The controller is
// back in idle in the cycle after the commit. One item is in work at a time.
// A new item may be accepted while the previous result waits, but its commit
// stalls until that result is taken.
// No clearing pass after reset: only slots below the fill count are read.
// ----------------------------------------------------------------------------
module load_table_newest_update_minmax_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ltnu_pkg::ID_BITS-1:0] i_proc_id,
    input  logic [ltnu_pkg::LOAD_W-1:0]  i_load,
    input  logic [ltnu_pkg::STAMP_W-1:0] i_stamp,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [ltnu_pkg::CNT_W-1:0]   o_entry_count,
    output logic [ltnu_pkg::ID_BITS-1:0] o_min_proc,
    output logic [ltnu_pkg::LOAD_W-1:0]  o_min_load,
    output logic [ltnu_pkg::ID_BITS-1:0] o_max_proc,
    output logic [ltnu_pkg::LOAD_W-1:0]  o_max_load
);

    ltnu_pkg::t_cmd cmd;
    ltnu_pkg::t_sts sts;

    ltnu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ltnu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_proc_id     (i_proc_id),
        .i_load        (i_load),
        .i_stamp       (i_stamp),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_min_proc    (o_min_proc),
        .o_min_load    (o_min_load),
        .o_max_proc    (o_max_proc),
        .o_max_load    (o_max_load)
    );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the processor load table with min/max query.
// Load reports go in over a valid/ready channel. A predictor holds its own
// copy of the table and works out, for each accepted report, the status,
// entry count and least/most loaded entries. Each result that comes out is
// compared with the oldest prediction. Both sides idle at random. One long
// receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    import ltnu_pkg::*;

    localparam int CLK_PERIOD = 8;

    typedef struct {
        t_status           status;
        logic [CNT_W-1:0]   count;
        logic [ID_BITS-1:0] min_proc;
        logic [LOAD_W-1:0]  min_load;
        logic [ID_BITS-1:0] max_proc;
        logic [LOAD_W-1:0]  max_load;
    } t_report_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [ID_BITS-1:0]   i_proc_id = '0;
    logic [LOAD_W-1:0]    i_load = '0;
    logic [STAMP_W-1:0]   i_stamp = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_entry_count;
    logic [ID_BITS-1:0]   o_min_proc;
    logic [LOAD_W-1:0]    o_min_load;
    logic [ID_BITS-1:0]   o_max_proc;
    logic [LOAD_W-1:0]    o_max_load;

    // predicted table
    logic [ID_BITS-1:0]   tbl_id    [ENTRIES];
    logic [LOAD_W-1:0]    tbl_load  [ENTRIES];
    logic [STAMP_W-1:0]   tbl_stamp [ENTRIES];
    int                   tbl_fill = 0;

    t_report_result       pending_results[$];
    int                   error_count = 0;
    bit                   tx_idle_on = 1'b1;
    bit                   rx_idle_on = 1'b1;
    int                   hold_req = 0;

    load_table_newest_update_minmax_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_proc_id     (i_proc_id),
        .i_load        (i_load),
        .i_stamp       (i_stamp),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_min_proc    (o_min_proc),
        .o_min_load    (o_min_load),
        .o_max_proc    (o_max_proc),
        .o_max_load    (o_max_load)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 1000000);
        $display("load_table_newest_update_minmax_unit verification failed");
        $finish;
    end

    function automatic int find_slot(input logic [ID_BITS-1:0] id);
        for (int k = 0; k < tbl_fill; k++) begin
            if (tbl_id[k] == id) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic void predict_report(input logic [ID_BITS-1:0] id,
                                           input logic [LOAD_W-1:0] ld,
                                           input logic [STAMP_W-1:0] st);
        t_report_result r;
        int             slot;
        slot = find_slot(id);
        if (slot >= 0) begin
            if (st > tbl_stamp[slot]) begin
                tbl_load[slot]  = ld;
                tbl_stamp[slot] = st;
                r.status = ST_REPLACED;
            end else begin
                r.status = ST_KEPT;
            end
        end else if (tbl_fill < ENTRIES) begin
            tbl_id[tbl_fill]    = id;
            tbl_load[tbl_fill]  = ld;
            tbl_stamp[tbl_fill] = st;
            tbl_fill++;
            r.status = ST_INSERTED;
        end else begin
            r.status = ST_DROPPED;
        end
        r.count    = CNT_W'(tbl_fill);
        r.min_proc = tbl_id[0];
        r.min_load = tbl_load[0];
        r.max_proc = tbl_id[0];
        r.max_load = tbl_load[0];
        for (int k = 1; k < tbl_fill; k++) begin
            if (tbl_load[k] < r.min_load) begin
                r.min_load = tbl_load[k];
                r.min_proc = tbl_id[k];
            end
            if (tbl_load[k] > r.max_load) begin
                r.max_load = tbl_load[k];
                r.max_proc = tbl_id[k];
            end
        end
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [LOAD_W-1:0] pick_load();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom;
        if (r < 75) return $urandom_range(0, 3);
        if (r < 85) return {16'($urandom_range(0, 3)), 16'h0000};
        if (r < 92) return '0;
        return '1;
    endfunction

    function automatic logic [STAMP_W-1:0] pick_stamp(input logic [ID_BITS-1:0] id);
        int slot;
        int r;
        slot = find_slot(id);
        r = $urandom_range(0, 99);
        if (slot < 0) return rand_stamp();
        if (r < 50) return tbl_stamp[slot] + STAMP_W'($urandom_range(1, 1000));
        if (r < 65) return tbl_stamp[slot];
        if (r < 80) return tbl_stamp[slot] - STAMP_W'($urandom_range(1, 1000));
        return rand_stamp();
    endfunction

    function automatic logic [ID_BITS-1:0] fresh_id();
        logic [ID_BITS-1:0] id;
        do begin
            id = ID_BITS'($urandom);
        end while (find_slot(id) >= 0);
        return id;
    endfunction

    function automatic logic [ID_BITS-1:0] known_id();
        return tbl_id[$urandom_range(0, tbl_fill - 1)];
    endfunction

    // called at a rising edge; returns at a rising edge
    task automatic offer_report(input logic [ID_BITS-1:0] id,
                                input logic [LOAD_W-1:0] ld,
                                input logic [STAMP_W-1:0] st);
        int gap;
        i_valid   <= 1'b1;
        i_proc_id <= id;
        i_load    <= ld;
        i_stamp   <= st;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predict_report(id, ld, st);
        gap = tx_idle_on ? draw_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic offer_mixed(input int new_pct);
        logic [ID_BITS-1:0] id;
        if (tbl_fill == 0 || $urandom_range(0, 99) < new_pct) begin
            id = fresh_id();
        end else begin
            id = known_id();
        end
        offer_report(id, pick_load(), pick_stamp(id));
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // result checker and receiver stalls
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        t_report_result e;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no report pending");
                error_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", 64'(e.status), 64'(o_status));
                check_field("entry_count", 64'(e.count), 64'(o_entry_count));
                check_field("min_proc", 64'(e.min_proc), 64'(o_min_proc));
                check_field("min_load", 64'(e.min_load), 64'(o_min_load));
                check_field("max_proc", 64'(e.max_proc), 64'(o_max_proc));
                check_field("max_load", 64'(e.max_load), 64'(o_max_load));
            end
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
            stall_left = draw_gap();
            i_ready <= (stall_left == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        offer_report(16'h0000, 32'hFFFF_FFFF, 48'h0);
        offer_report(16'hFFFF, 32'h0000_0000, '1);
        offer_report(16'h0000, 32'h0000_0005, 48'h0);             // equal stamp, kept
        offer_report(16'hFFFF, 32'h0000_0007, '1);                // equal at top stamp
        offer_report(16'hFFFF, 32'h0000_0009, 48'd100);           // older, kept
        offer_report(16'h0000, 32'h0000_0000, 48'd1);             // replaced, all loads tie
        offer_report(16'h00A5, 32'hFFFF_FFFF, 48'd2);
        offer_report(16'h5A00, 32'hFFFF_FFFF, 48'd3);             // max tie, lower slot wins
        offer_report(16'h1234, 32'h0001_8000, 48'h8000_0000_0000);
        offer_report(16'h1234, 32'h0001_0000, 48'h8000_0000_0001);
        offer_report(16'h5A00, 32'h0000_0000, 48'd4);             // min tie over three slots
        offer_report(16'h0000, 32'hFFFF_FFFE, '1);
        offer_report(16'hFFFF, 32'hFFFF_FFFF, '1);
        offer_report(16'h5555, 32'h5555_5555, 48'h5555_5555_5555);
        offer_report(16'hAAAA, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
    endtask

    task automatic test_update_mix();
        repeat (120) offer_mixed(25);
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (60) offer_mixed(10);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_fill_to_capacity();
        logic [ID_BITS-1:0] id;
        while (tbl_fill < ENTRIES) begin
            id = fresh_id();
            offer_report(id, pick_load(), rand_stamp());
        end
        repeat (6) begin
            id = fresh_id();
            offer_report(id, pick_load(), rand_stamp());
        end
    endtask

    task automatic test_back_pressure();
        hold_req = 400;
        repeat (20) offer_mixed(20);
    endtask

    task automatic test_full_table_mix();
        logic [ID_BITS-1:0] id;
        int                 r;
        repeat (800) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                offer_mixed(0);
            end else if (r < 85) begin
                id = fresh_id();
                offer_report(id, pick_load(), pick_stamp(id));
            end else begin
                offer_report(16'($urandom), 32'($urandom), rand_stamp());
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_update_mix();
        test_no_idle();
        test_fill_to_capacity();
        test_back_pressure();
        test_full_table_mix();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("load_table_newest_update_minmax_unit verification clean");
        end else begin
            $display("load_table_newest_update_minmax_unit verification failed");
        end
        $finish;
    end

endmodule
